FILE: sv/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// shared widths, register indexes, reset values and sequencer states of the
// fixed-point pid regulator with integral clamp
// ----------------------------------------------------------------------------
package pidaw_pkg;

  // field widths
  localparam int GainW    = 24;                 // q8.16 gains
  localparam int ValW     = 16;                 // q8.8 values
  localparam int DtW      = 16;                 // q4.12 seconds
  localparam int LimW     = 31;                 // integral bound
  localparam int AccW     = 32;                 // integral accumulator
  localparam int ErrW     = ValW + 1;           // setpoint minus measurement
  localparam int DiffW    = ErrW + 1;           // error change
  localparam int FracDt   = 12;                 // fraction bits of dt
  localparam int ErrProdW = ErrW + DtW + 1;     // err * dt, dt taken as signed
  localparam int DivNumW  = ErrW + FracDt;      // |diff| * 4096
  localparam int DerivW   = DivNumW + 1;        // signed derivative
  localparam int PropW    = ErrW + GainW;
  localparam int IntegW   = AccW + GainW;
  localparam int DervPW   = DerivW + GainW;
  localparam int SumW     = IntegW + 1;
  localparam int OutShift = 16;
  localparam int ResW     = SumW - OutShift;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = LimW;

  localparam logic [CfgIdxW-1:0] RegPropGain  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIntegGain = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDerivGain = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTarget    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFloor     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCeiling   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLimit     = 3'd6;

  // register reset values
  localparam logic signed [GainW-1:0] PropGainRst  = 24'sd327680;
  localparam logic signed [GainW-1:0] IntegGainRst = 24'sd6554;
  localparam logic signed [GainW-1:0] DerivGainRst = 24'sd65536;
  localparam logic signed [ValW-1:0]  TargetRst    = 16'sd6400;
  localparam logic signed [ValW-1:0]  FloorRst     = 16'sd0;
  localparam logic signed [ValW-1:0]  CeilingRst   = 16'sd25600;
  localparam logic [LimW-1:0]         LimitRst     = 31'd256000;

  // one second in q4.12, used for a zero time step
  localparam logic [DtW-1:0] DtOne = 16'd4096;

  // command codes carried in tuser
  localparam logic CmdStep  = 1'b0;
  localparam logic CmdClear = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StLoad,
    StMulDiv,
    StAccum,
    StClamp,
    StGainGo,
    StGainWait,
    StSum1,
    StSum2,
    StSat,
    StOut
  } state_e;

endpackage

FILE: sv/pidaw_sermul.sv
// ----------------------------------------------------------------------------
// pidaw_sermul
// serial-parallel signed multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module pidaw_sermul #(
  parameter int AW = 17,
  parameter int BW = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic                    busy_o,
  output logic signed [AW+BW-1:0] prod_o
);

  localparam int CntW = $clog2(BW + 1);

  logic                   busy_q;
  logic [CntW-1:0]        cnt_q;
  logic signed [AW-1:0]   a_q;
  logic [BW-1:0]          b_q;
  logic signed [AW:0]     p_q;
  logic [BW-1:0]          lo_q;
  logic                   last;
  logic signed [AW+1:0]   addend;
  logic signed [AW+1:0]   sum;

  // the top multiplier bit has negative weight
  always_comb begin
    last = (cnt_q == CntW'(BW - 1));
    if (!b_q[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -(AW + 2)'(a_q);
    end else begin
      addend = (AW + 2)'(a_q);
    end
    sum = (AW + 2)'(p_q) + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      b_q  <= b_i;
      p_q  <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      p_q  <= sum[AW+1:1];
      lo_q <= {sum[0], lo_q[BW-1:1]};
      b_q  <= {1'b0, b_q[BW-1:1]};
    end
  end

  assign busy_o = busy_q;
  assign prod_o = {p_q[AW-1:0], lo_q};

endmodule

FILE: sv/pidaw_serdiv.sv
// ----------------------------------------------------------------------------
// pidaw_serdiv
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pidaw_serdiv #(
  parameter int NW = 29,
  parameter int DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [NW-1:0] quo_o
);

  localparam int CntW = $clog2(NW + 1);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DW-1:0]   d_q;
  logic [DW-1:0]   r_q;
  logic [NW-1:0]   q_q;
  logic            last;
  logic [DW:0]     trial;
  logic            fits;
  logic [DW:0]     rem;

  // numerator bits shift out at the top, quotient bits shift in at the bottom
  always_comb begin
    last  = (cnt_q == CntW'(NW - 1));
    trial = {r_q, q_q[NW-1]};
    fits  = (trial >= {1'b0, d_q});
    rem   = fits ? (trial - {1'b0, d_q}) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q <= den_i;
      r_q <= '0;
      q_q <= num_i;
    end else if (busy_q) begin
      r_q <= rem[DW-1:0];
      q_q <= {q_q[NW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = q_q;

endmodule

FILE: sv/pid_controller_antiwindup.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// fixed-point pid regulator with a symmetric clamp on the integral
// ----------------------------------------------------------------------------
// channel | dir | transaction contents
// s_axis  | in  | tdata: measured_value [15:0], time_step [31:16]; tuser: command
// m_axis  | out | tdata: drive_value [15:0]
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i; one register per write, no read
//
// a control step runs the 29 bit restoring divide for the derivative with the
// err*dt multiply alongside, then the integral update and clamp, then the
// three 24 bit gain multiplies in parallel, then the two sums and the output
// saturation
// a clear command skips the arithmetic and goes straight to the output
// one step is in flight at a time; the result sits in an output register, so
// a stalled m_axis only holds the block once the next result is ready
// reset clears the integral and the previous error at once, no clearing pass
// ----------------------------------------------------------------------------
module pid_controller_antiwindup (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // measured_value, time_step
  input  logic                            s_axis_tuser,  // command
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // drive_value
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [pidaw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pidaw_pkg::CfgDataW-1:0]  cfg_data_i
);

  import pidaw_pkg::*;

  // configuration registers
  logic signed [GainW-1:0] prop_gain_q;
  logic signed [GainW-1:0] integ_gain_q;
  logic signed [GainW-1:0] deriv_gain_q;
  logic signed [ValW-1:0]  target_q;
  logic signed [ValW-1:0]  floor_q;
  logic signed [ValW-1:0]  ceil_q;
  logic [LimW-1:0]         limit_q;

  // sequencer
  state_e state_q, state_d;
  logic   in_take;
  logic   start_ed;     // err*dt multiply and derivative divide
  logic   start_g;      // gain multiplies
  logic   out_load;

  // captured transaction
  logic                    cmd_q;
  logic signed [ValW-1:0]  meas_q;
  logic [DtW-1:0]          dt_q;

  // controller state and working registers
  logic signed [AccW-1:0]  acc_q;
  logic signed [ErrW-1:0]  last_err_q;
  logic signed [ErrW-1:0]  err_q;
  logic                    diff_neg_q;
  logic signed [AccW:0]    acc_sum_q;
  logic signed [SumW-1:0]  sum_q;
  logic signed [ValW-1:0]  res_q;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic [ValW-1:0]         out_data_q;

  // load-step arithmetic
  logic signed [ErrW-1:0]  err_c;
  logic signed [DiffW-1:0] diff_c;
  logic [DiffW-1:0]        diff_mag_c;
  logic [DivNumW-1:0]      num_c;
  logic [DtW-1:0]          dtn_c;

  // unit results
  logic                       emul_busy, div_busy;
  logic                       pmul_busy, imul_busy, dmul_busy;
  logic signed [ErrProdW-1:0] eprod;
  logic [DivNumW-1:0]         quo;
  logic [DerivW-1:0]          quo_ext;
  logic signed [DerivW-1:0]   deriv_c;
  logic signed [PropW-1:0]    pprod;
  logic signed [IntegW-1:0]   iprod;
  logic signed [DervPW-1:0]   dprod;

  // clamp and saturation
  logic signed [AccW:0]    lim_pos, lim_neg;
  logic signed [ResW-1:0]  res_c, res_hi_c, floor_ext, ceil_ext;

  // --------------------------------------------------------------------------
  // configuration, unknown indexes are dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= PropGainRst;
      integ_gain_q <= IntegGainRst;
      deriv_gain_q <= DerivGainRst;
      target_q     <= TargetRst;
      floor_q      <= FloorRst;
      ceil_q       <= CeilingRst;
      limit_q      <= LimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPropGain:  prop_gain_q  <= cfg_data_i[GainW-1:0];
        RegIntegGain: integ_gain_q <= cfg_data_i[GainW-1:0];
        RegDerivGain: deriv_gain_q <= cfg_data_i[GainW-1:0];
        RegTarget:    target_q     <= cfg_data_i[ValW-1:0];
        RegFloor:     floor_q      <= cfg_data_i[ValW-1:0];
        RegCeiling:   ceil_q       <= cfg_data_i[ValW-1:0];
        RegLimit:     limit_q      <= cfg_data_i[LimW-1:0];
        default:      ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    start_ed      = 1'b0;
    start_g       = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        if (cmd_q == CmdClear) begin
          state_d = StOut;
        end else begin
          start_ed = 1'b1;
          state_d  = StMulDiv;
        end
      end
      StMulDiv: begin
        if (!emul_busy && !div_busy) begin
          state_d = StAccum;
        end
      end
      StAccum: state_d = StClamp;
      StClamp: state_d = StGainGo;
      StGainGo: begin
        start_g = 1'b1;
        state_d = StGainWait;
      end
      StGainWait: begin
        if (!pmul_busy && !imul_busy && !dmul_busy) begin
          state_d = StSum1;
        end
      end
      StSum1: state_d = StSum2;
      StSum2: state_d = StSat;
      StSat:  state_d = StOut;
      StOut: begin
        // wait for the previous result to leave the output register
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_take = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // load step: error, error change, derivative numerator, effective dt
  // --------------------------------------------------------------------------
  always_comb begin
    err_c      = ErrW'(target_q) - ErrW'(meas_q);
    diff_c     = DiffW'(err_c) - DiffW'(last_err_q);
    diff_mag_c = diff_c[DiffW-1] ? (DiffW'(0) - diff_c) : diff_c;
    num_c      = {diff_mag_c[ErrW-1:0], {FracDt{1'b0}}};
    dtn_c      = (dt_q == '0) ? DtOne : dt_q;
  end

  // err * dt, dt enters as a non-negative signed value
  pidaw_sermul #(
    .AW (ErrW),
    .BW (DtW + 1)
  ) u_emul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_ed),
    .a_i     (err_c),
    .b_i     ({1'b0, dtn_c}),
    .busy_o  (emul_busy),
    .prod_o  (eprod)
  );

  // |diff| * 4096 / dt, the sign goes back on afterwards (truncation toward zero)
  pidaw_serdiv #(
    .NW (DivNumW),
    .DW (DtW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_ed),
    .num_i   (num_c),
    .den_i   (dtn_c),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  always_comb begin
    quo_ext = {1'b0, quo};
    deriv_c = diff_neg_q ? (DerivW'(0) - quo_ext) : quo_ext;
  end

  // --------------------------------------------------------------------------
  // gain products, all three start together and run in parallel
  // --------------------------------------------------------------------------
  pidaw_sermul #(
    .AW (ErrW),
    .BW (GainW)
  ) u_pmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_g),
    .a_i     (err_q),
    .b_i     (prop_gain_q),
    .busy_o  (pmul_busy),
    .prod_o  (pprod)
  );

  pidaw_sermul #(
    .AW (AccW),
    .BW (GainW)
  ) u_imul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_g),
    .a_i     (acc_q),
    .b_i     (integ_gain_q),
    .busy_o  (imul_busy),
    .prod_o  (iprod)
  );

  pidaw_sermul #(
    .AW (DerivW),
    .BW (GainW)
  ) u_dmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_g),
    .a_i     (deriv_c),
    .b_i     (deriv_gain_q),
    .busy_o  (dmul_busy),
    .prod_o  (dprod)
  );

  // --------------------------------------------------------------------------
  // integral clamp and output saturation (ceiling first, then floor)
  // --------------------------------------------------------------------------
  always_comb begin
    lim_pos   = (AccW + 1)'(limit_q);
    lim_neg   = (AccW + 1)'(0) - lim_pos;
    res_c     = $signed(sum_q[SumW-1:OutShift]);
    ceil_ext  = ResW'(ceil_q);
    floor_ext = ResW'(floor_q);
    res_hi_c  = (res_c > ceil_ext) ? ceil_ext : res_c;
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      last_err_q <= '0;
    end else if (state_q == StLoad) begin
      if (cmd_q == CmdClear) begin
        acc_q      <= '0;
        last_err_q <= '0;
      end else begin
        last_err_q <= err_c;
      end
    end else if (state_q == StClamp) begin
      if (acc_sum_q > lim_pos) begin
        acc_q <= lim_pos[AccW-1:0];
      end else if (acc_sum_q < lim_neg) begin
        acc_q <= lim_neg[AccW-1:0];
      end else begin
        acc_q <= acc_sum_q[AccW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= s_axis_tuser;
      meas_q <= s_axis_tdata[ValW-1:0];
      dt_q   <= s_axis_tdata[ValW+DtW-1:ValW];
    end
    case (state_q)
      StLoad: begin
        err_q      <= err_c;
        diff_neg_q <= diff_c[DiffW-1];
        res_q      <= '0;    // result of a clear
      end
      StAccum: begin
        // arithmetic shift of err*dt back to q.8
        acc_sum_q <= (AccW + 1)'(acc_q) + (AccW + 1)'($signed(eprod[ErrProdW-1:FracDt]));
      end
      StSum1: sum_q <= SumW'(iprod) + SumW'(pprod);
      StSum2: sum_q <= sum_q + SumW'(dprod);
      StSat: begin
        res_q <= (res_hi_c < floor_ext) ? floor_q : res_hi_c[ValW-1:0];
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: sv/pidaw_chk.sv
// ----------------------------------------------------------------------------
// pidaw_chk
// port-level checks of the pid regulator, bound to the top level
// ----------------------------------------------------------------------------
module pidaw_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [31:0]                     s_axis_tdata,  // measured_value, time_step
  input logic                            s_axis_tuser,  // command
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [15:0]                     m_axis_tdata,  // drive_value
  input logic                            cfg_we_i,
  input logic [pidaw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input logic [pidaw_pkg::CfgDataW-1:0]  cfg_data_i
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // after an accept the input stays not ready through the load state and the state after it
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken again too early");

  // a new result is posted only as the sequencer returns to idle
  a_result_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result posted while still busy");

  // no result appears in the cycle right after an accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result without computation");

endmodule

bind pid_controller_antiwindup pidaw_chk u_pidaw_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_we_i      (cfg_we_i),
  .cfg_idx_i     (cfg_idx_i),
  .cfg_data_i    (cfg_data_i)
);

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fixed-point pid regulator with integral clamp
// ----------------------------------------------------------------------------
// a table of directed transactions runs first, then six register settings
// each get a batch of random control steps and clears; a predictor that
// mirrors the controller state computes every drive value, which is queued
// and compared against each m_axis transaction in order
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pidaw_pkg::*;

  // write to this index must be ignored by the block
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  localparam int NumSettings   = 6;
  localparam int StepsPerBatch = 322;
  localparam int HoldOffCycles = 400;   // long m_axis stall for back-pressure
  localparam int StallLimit    = 4000;  // cycles with no transaction at all
  localparam int DrainCycles   = 70;    // one step latency plus margin

  // one input transaction
  typedef struct packed {
    logic        cmd;
    logic [15:0] dt;
    logic [15:0] meas;
  } pid_sample_t;

  // directed row: typed marks a drive value read straight off the spec
  typedef struct packed {
    logic        typed;
    logic [15:0] drive;
    logic        cmd;
    logic [15:0] dt;
    logic [15:0] meas;
  } pid_row_t;

  localparam int NumDirected = 17;
  localparam pid_row_t DirRows [NumDirected] = '{
    // clear straight out of reset
    '{1'b1, 16'd0,      CmdClear, 16'h0000, 16'h0000},
    // lowest measurement with zero dt: every term positive, pinned at ceiling
    '{1'b1, CeilingRst, CmdStep,  16'h0000, 16'h8000},
    // highest measurement: large negative error and derivative, pinned at floor
    '{1'b1, FloorRst,   CmdStep,  16'h0000, 16'h7FFF},
    // clear ignores measurement and dt
    '{1'b1, 16'd0,      CmdClear, 16'hFFFF, 16'h1234},
    // zero error from a clean state: all terms vanish
    '{1'b1, 16'd0,      CmdStep,  16'h1000, TargetRst},
    // longest dt, then shortest dt for a steep derivative
    '{1'b0, 16'd0,      CmdStep,  16'hFFFF, 16'h0000},
    '{1'b0, 16'd0,      CmdStep,  16'h0001, 16'hFF9C},
    '{1'b0, 16'd0,      CmdStep,  16'h8000, 16'h3039},
    '{1'b0, 16'd0,      CmdStep,  16'h7FFF, 16'hFFFF},
    '{1'b0, 16'd0,      CmdStep,  16'hAAAA, 16'h5555},
    '{1'b0, 16'd0,      CmdStep,  16'h5555, 16'hAAAA},
    // wind the integral up into its positive limit
    '{1'b0, 16'd0,      CmdStep,  16'hFFFF, 16'h8000},
    '{1'b0, 16'd0,      CmdStep,  16'hFFFF, 16'h8000},
    '{1'b0, 16'd0,      CmdStep,  16'hFFFF, 16'h8000},
    '{1'b0, 16'd0,      CmdStep,  16'hFFFF, 16'h8000},
    // swing hard the other way, once with zero dt
    '{1'b0, 16'd0,      CmdStep,  16'hFFFF, 16'h7FFF},
    '{1'b0, 16'd0,      CmdStep,  16'h0000, 16'h7FFF}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;   // measured_value [15:0], time_step [31:16]
  logic                s_axis_tuser;   // command
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;   // drive_value
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // register mirror, starts at the reset values
  logic signed [GainW-1:0] kp_q     = PropGainRst;
  logic signed [GainW-1:0] ki_q     = IntegGainRst;
  logic signed [GainW-1:0] kd_q     = DerivGainRst;
  logic signed [ValW-1:0]  target_q = TargetRst;
  logic signed [ValW-1:0]  floor_q  = FloorRst;
  logic signed [ValW-1:0]  ceil_q   = CeilingRst;
  logic [LimW-1:0]         limit_q  = LimitRst;

  // controller state mirror
  logic signed [AccW-1:0] integ_acc = '0;
  logic signed [ErrW-1:0] prev_err  = '0;

  logic [CfgDataW-1:0] next_regs [7];  // values for the next register load
  logic [15:0]         drive_q [$];    // drive values still owed by the block
  int                  fault_cnt   = 0;
  int                  quiet_cycles = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  bit                  hold_off_req  = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pid_controller_antiwindup u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // advance the mirrored controller by one transaction, return its drive value
  function automatic logic [15:0] pid_next_drive(pid_sample_t smp);
    longint err, dt, acc, lim, deriv, sum, res;
    if (smp.cmd == CmdClear) begin
      integ_acc = '0;
      prev_err  = '0;
      return '0;
    end
    // zero dt stands for one second
    dt  = (smp.dt == '0) ? longint'(DtOne) : longint'(smp.dt);
    err = longint'(target_q) - longint'($signed(smp.meas));
    lim = longint'(limit_q);
    // integral: err*dt back to q.8, floor rounding, symmetric clamp
    acc = longint'(integ_acc) + ((err * dt) >>> FracDt);
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    // derivative truncates toward zero, same as sv integer division
    deriv = ((err - longint'(prev_err)) * longint'(DtOne)) / dt;
    integ_acc = acc[AccW-1:0];
    prev_err  = err[ErrW-1:0];
    sum = longint'(kp_q) * err + longint'(ki_q) * acc + longint'(kd_q) * deriv;
    res = sum >>> OutShift;
    // ceiling first, so a floor above the ceiling wins
    if (res > longint'(ceil_q)) res = longint'(ceil_q);
    if (res < longint'(floor_q)) res = longint'(floor_q);
    return res[15:0];
  endfunction

  // random transaction, mostly steps with the measurement near the setpoint
  function automatic pid_sample_t rand_sample();
    pid_sample_t smp;
    int          pick;
    smp.cmd = ($urandom_range(99) < 4) ? CmdClear : CmdStep;
    pick = $urandom_range(9);
    if (pick < 6) smp.meas = target_q + 16'($urandom_range(0, 1023)) - 16'd512;
    else if (pick < 8) smp.meas = 16'($urandom);
    else if (pick == 8) smp.meas = 16'h8000;
    else smp.meas = 16'h7FFF;
    pick = $urandom_range(9);
    if (pick == 0) smp.dt = '0;
    else if (pick < 7) smp.dt = 16'($urandom_range(1, 8192));
    else if (pick < 9) smp.dt = 16'($urandom);
    else smp.dt = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0001;
    return smp;
  endfunction

  // offer one transaction, optionally after a random gap; valid stays high
  // afterwards so back-to-back transactions never drop it
  task automatic send_item(pid_sample_t smp, logic typed, logic [15:0] typed_drive);
    logic [15:0] predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {smp.dt, smp.meas};
    s_axis_tuser  <= smp.cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = pid_next_drive(smp);
    drive_q.push_back(typed ? typed_drive : predicted);
  endtask

  // stop offering and wait until every owed drive value has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write all seven registers from next_regs, plus one ignored write
  task automatic load_registers();
    for (int k = 0; k < 7; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 3'(k);
      cfg_data_i <= next_regs[k];
      @(posedge clk_i);
    end
    // unused index: nothing may change
    cfg_idx_i  <= RegUnused;
    cfg_data_i <= 31'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    kp_q     = next_regs[RegPropGain][GainW-1:0];
    ki_q     = next_regs[RegIntegGain][GainW-1:0];
    kd_q     = next_regs[RegDerivGain][GainW-1:0];
    target_q = next_regs[RegTarget][ValW-1:0];
    floor_q  = next_regs[RegFloor][ValW-1:0];
    ceil_q   = next_regs[RegCeiling][ValW-1:0];
    limit_q  = next_regs[RegLimit];
    @(posedge clk_i);
  endtask

  // m_axis ready: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // check every drive value against the oldest owed one
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (drive_q.size() == 0) begin
        $error("drive_value with no transaction owed: got %0d", $signed(m_axis_tdata));
        fault_cnt++;
      end else begin
        if (m_axis_tdata !== drive_q[0]) begin
          $error("drive_value mismatch: expected %0d, got %0d",
                 $signed(drive_q[0]), $signed(m_axis_tdata));
          fault_cnt++;
        end
        void'(drive_q.pop_front());
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    pid_sample_t smp;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CmdStep;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegPropGain;
    cfg_data_i    = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int setting = 0; setting < NumSettings; setting++) begin
      // idling pattern: slow receiver, then slow sender, then full speed
      if (setting < 2) begin
        send_idle_pct = 15;
        recv_idle_pct = 69;
      end else if (setting < 4) begin
        send_idle_pct = 69;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (setting > 0) begin
        wait_drained();
        // defaults: moderate random gains, full output range
        next_regs[RegPropGain]  = 31'(int'($urandom_range(0, 2**21)) - 2**20);
        next_regs[RegIntegGain] = 31'(int'($urandom_range(0, 2**19)) - 2**18);
        next_regs[RegDerivGain] = 31'(int'($urandom_range(0, 2**19)) - 2**18);
        next_regs[RegTarget]    = 31'($urandom_range(0, 65535));
        next_regs[RegFloor]     = 31'(-32768);
        next_regs[RegCeiling]   = 31'(32767);
        next_regs[RegLimit]     = 31'($urandom_range(0, 2**24));
        case (setting)
          1: begin
            // extreme gains, extreme setpoint, unbounded integral
            next_regs[RegPropGain]  = 31'(-8388608);
            next_regs[RegIntegGain] = 31'(8388607);
            next_regs[RegDerivGain] = 31'(-8388608);
            next_regs[RegTarget]    = 31'(-32768);
            next_regs[RegLimit]     = 31'h7FFF_FFFF;
          end
          2: begin
            // floor above ceiling: output sits at the floor
            next_regs[RegFloor]   = 31'(1000);
            next_regs[RegCeiling] = 31'(-1000);
          end
          3: begin
            // zero limit keeps the integral at zero
            next_regs[RegLimit] = '0;
          end
          4: begin
            // everything random, including a possibly crossed output window
            for (int k = 0; k < 7; k++) next_regs[k] = 31'($urandom);
          end
          default: begin
            next_regs[RegPropGain]  = 31'(8388607);
            next_regs[RegIntegGain] = 31'(-8388608);
            next_regs[RegDerivGain] = 31'(8388607);
            next_regs[RegTarget]    = 31'(32767);
            next_regs[RegLimit]     = 31'($urandom_range(0, 65535));
          end
        endcase
        load_registers();
      end else begin
        for (int r = 0; r < NumDirected; r++) begin
          smp.cmd  = DirRows[r].cmd;
          smp.dt   = DirRows[r].dt;
          smp.meas = DirRows[r].meas;
          send_item(smp, DirRows[r].typed, DirRows[r].drive);
        end
      end

      for (int n = 0; n < StepsPerBatch; n++) begin
        // long m_axis hold-off while we keep offering: the block must stall
        if (setting == 0 && n == 40) hold_off_req = 1'b1;
        // sender pause until the block has handed back everything
        if (setting == 2 && n == 100) wait_drained();
        send_item(rand_sample(), 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fault_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
